>>> rtl/msf_pkg.sv
package msf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CNT_W     = 25;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_W       = FRAC_BITS + 1;
  localparam int unsigned DEN_W     = CNT_W + 2;
  localparam int unsigned REM_W     = DEN_W + 1;
  localparam int unsigned STEP_W    = $clog2(Q_W);

  localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(25'd16777216);
  localparam logic [PIX_W-1:0]  PIX_FG    = 8'd255;
  localparam logic [PIX_W-1:0]  PIX_BG    = 8'd0;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

  typedef struct packed {
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] fn;
    logic [CNT_W-1:0] tn;
  } count_set_t;

  typedef enum logic [1:0] {
    RATIO_PREC,
    RATIO_REC,
    RATIO_F
  } ratio_sel_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

>>> rtl/mask_fmeasure_scorer.sv
// Pixels are taken at one beat per cycle while in_tready is high; each updates one class count.
// Once the last pixel of an image is taken its counts are queued; the back end fetches them,
// forms three ratios, each a setup step and a 17-bit quotient, and loads them, raising out_tvalid.
// The shared divider works on one image at a time; up to two finished images wait for
// it, and in_tready is low while both places are taken.
// Reset is synchronous, active low, and clears the counts, the queue and the output valid.
module mask_fmeasure_scorer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // truth_pixel[7:0], seg_pixel[15:8]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // precision_q16, recall_q16, fscore_q16, true_pos_count,
                                   // false_pos_count, false_neg_count, true_neg_count, zero pad
  output logic [1:0]   out_tuser   // precision_undefined, recall_undefined
);
  import msf_pkg::*;

  logic       q_push, q_full;
  count_set_t front_cnt, q_cnt, res_cnt;
  logic       q_valid, q_pop;
  logic [Q_W-1:0] prec, rec, fsc;
  logic       prec_undef, rec_undef;

  msf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (in_tvalid),
    .pix_ready   (in_tready),
    .truth_pixel (in_tdata[7:0]),
    .seg_pixel   (in_tdata[15:8]),
    .last_pixel  (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (front_cnt)
  );

  msf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (front_cnt),
    .wr_en    (q_push),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_cnt)
  );

  msf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_data              (q_cnt),
    .res_valid           (out_tvalid),
    .res_ready           (out_tready),
    .precision_q16       (prec),
    .recall_q16          (rec),
    .fscore_q16          (fsc),
    .precision_undefined (prec_undef),
    .recall_undefined    (rec_undef),
    .res_counts          (res_cnt)
  );

  assign out_tdata = {1'b0, res_cnt.tn, res_cnt.fn, res_cnt.fp, res_cnt.tp, fsc, rec, prec};
  assign out_tuser = {rec_undef, prec_undef};

endmodule

>>> rtl/msf_front.sv
module msf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  logic [7:0]          truth_pixel,
  input  logic [7:0]          seg_pixel,
  input  logic                last_pixel,
  input  logic                q_full,
  output logic                q_push,
  output msf_pkg::count_set_t q_data
);
  import msf_pkg::*;

  count_set_t cnt_r, cnt_nxt, cnt_inc;
  logic       accept;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c < CNT_CAP) ? c + CNT_W'(1) : c;
  endfunction

  assign pix_ready = !q_full;
  assign accept    = pix_valid && pix_ready;

  always_comb begin
    cnt_inc = cnt_r;
    if (truth_pixel == seg_pixel) begin
      if (truth_pixel == PIX_FG) begin
        cnt_inc.tp = sat_inc(cnt_r.tp);
      end else begin
        cnt_inc.tn = sat_inc(cnt_r.tn);
      end
    end else begin
      if (truth_pixel == PIX_BG) begin
        cnt_inc.fp = sat_inc(cnt_r.fp);
      end else begin
        cnt_inc.fn = sat_inc(cnt_r.fn);
      end
    end
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = last_pixel ? '0 : cnt_inc;
    end
  end

  assign q_push = accept && last_pixel;
  assign q_data = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/msf_queue.sv
module msf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  msf_pkg::count_set_t wr_data,
  input  logic                wr_en,
  output logic                full,
  output logic                rd_valid,
  input  logic                rd_en,
  output msf_pkg::count_set_t rd_data
);
  import msf_pkg::*;

  count_set_t  mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  fill_r;
  logic        do_wr, do_rd;

  assign full     = (fill_r == 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_wr, do_rd})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

>>> rtl/msf_back.sv
module msf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  msf_pkg::count_set_t q_data,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [16:0]         precision_q16,
  output logic [16:0]         recall_q16,
  output logic [16:0]         fscore_q16,
  output logic                precision_undefined,
  output logic                recall_undefined,
  output msf_pkg::count_set_t res_counts
);
  import msf_pkg::*;

  back_state_t      state_r, state_nxt;
  ratio_sel_t       sel_r, sel_nxt;
  count_set_t       cnt_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   quot_r, quot_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [Q_W-1:0]   prec_r, rec_r, f_r;
  logic [Q_W-1:0]   quot_final;
  logic             out_valid_r;
  logic             load_cnt, store_q, load_out;

  logic [REM_W-1:0] cur;
  logic             fits;
  logic [CNT_W:0]   sum_p, sum_r;
  logic [DEN_W-1:0] sum_f;

  assign sum_p = {1'b0, cnt_r.tp} + {1'b0, cnt_r.fp};
  assign sum_r = {1'b0, cnt_r.tp} + {1'b0, cnt_r.fn};
  assign sum_f = {1'b0, cnt_r.tp, 1'b0} + DEN_W'(cnt_r.fp) + DEN_W'(cnt_r.fn);

  assign cur  = (step_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign fits = (cur >= {1'b0, den_r});
  assign quot_final = (den_r == '0) ? '0 : {quot_r[Q_W-2:0], fits};

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quot_nxt  = quot_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    load_cnt  = 1'b0;
    store_q   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          load_cnt  = 1'b1;
          sel_nxt   = RATIO_PREC;
          state_nxt = BK_SETUP;
        end
      end
      BK_SETUP: begin
        step_nxt = '0;
        quot_nxt = '0;
        unique case (sel_r)
          RATIO_PREC: begin
            rem_nxt = REM_W'(cnt_r.tp);
            den_nxt = DEN_W'(sum_p);
          end
          RATIO_REC: begin
            rem_nxt = REM_W'(cnt_r.tp);
            den_nxt = DEN_W'(sum_r);
          end
          default: begin
            rem_nxt = REM_W'({cnt_r.tp, 1'b0});
            den_nxt = sum_f;
          end
        endcase
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        rem_nxt  = fits ? cur - {1'b0, den_r} : cur;
        quot_nxt = {quot_r[Q_W-2:0], fits};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          store_q = 1'b1;
          if (sel_r == RATIO_F) begin
            state_nxt = BK_DONE;
          end else begin
            sel_nxt   = (sel_r == RATIO_PREC) ? RATIO_REC : RATIO_F;
            state_nxt = BK_SETUP;
          end
        end
      end
      BK_DONE: begin
        if (!out_valid_r || res_ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sel_r       <= RATIO_PREC;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
    if (load_cnt) begin
      cnt_r <= q_data;
    end
    if (store_q) begin
      unique case (sel_r)
        RATIO_PREC: prec_r <= quot_final;
        RATIO_REC:  rec_r  <= quot_final;
        default:    f_r    <= quot_final;
      endcase
    end
    if (load_out) begin
      precision_q16       <= prec_r;
      recall_q16          <= rec_r;
      fscore_q16          <= f_r;
      precision_undefined <= (sum_p == '0);
      recall_undefined    <= (sum_r == '0);
      res_counts          <= cnt_r;
    end
  end

  assign res_valid = out_valid_r;

endmodule
